[src/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants, codes and types of the positional list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // compare width wide enough for count and position plus one
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_POS  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[src/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// one list entry: holds, loads, or takes its left or right neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell (
  input  wire logic                            clk,
  input  wire logic [ple_pkg::IDX_W-1:0]       my_idx,
  input  wire ple_pkg::cell_cmd_t              cmd,
  input  wire logic signed [ple_pkg::VAL_W-1:0] left_data,
  input  wire logic signed [ple_pkg::VAL_W-1:0] right_data,
  output logic signed [ple_pkg::VAL_W-1:0]      data,
  output logic signed [ple_pkg::VAL_W-1:0]      rd_data
);

  logic signed [ple_pkg::VAL_W-1:0] data_r;
  logic signed [ple_pkg::VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (my_idx > cmd.idx) begin
        data_nxt = left_data;
      end else if (my_idx == cmd.idx) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.del) begin
      if (my_idx >= cmd.idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // selected entry, zero elsewhere so the row can be or-reduced
  assign rd_data = (cmd.del && (my_idx == cmd.idx)) ? data_r : '0;

endmodule

`default_nettype wire

[src/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// action decode, range checks and fill count for the cell row
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              fire,
  input  wire logic [ple_pkg::ACT_W-1:0]         action,
  input  wire logic signed [ple_pkg::VAL_W-1:0]  value,
  input  wire logic [ple_pkg::POS_W-1:0]         position,
  output ple_pkg::cell_cmd_t                     cmd,
  output logic [ple_pkg::ST_W-1:0]               status,
  output logic [ple_pkg::OCC_W-1:0]              occupancy
);

  logic [ple_pkg::CNT_W-1:0] cnt_r;
  logic [ple_pkg::CNT_W-1:0] cnt_nxt;
  logic [ple_pkg::CMP_W-1:0] cnt_x;
  logic [ple_pkg::CMP_W-1:0] pos_x;
  logic [ple_pkg::CMP_W-1:0] idx_x;
  logic [ple_pkg::CMP_W-1:0] cnt_nxt_x;
  logic                      full;
  logic                      empty;
  logic                      do_ins;
  logic                      do_del;

  assign cnt_x = ple_pkg::CMP_W'(cnt_r);
  assign pos_x = ple_pkg::CMP_W'(position);
  assign full  = (cnt_r == ple_pkg::CNT_W'(ple_pkg::DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    status = ple_pkg::ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx_x  = '0;
    unique case (action)
      ple_pkg::ACT_INS_HEAD: begin
        if (full) status = ple_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ple_pkg::ACT_INS_TAIL: begin
        if (full) status = ple_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          idx_x  = cnt_x;
        end
      end
      ple_pkg::ACT_DEL_HEAD: begin
        if (empty) status = ple_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      ple_pkg::ACT_DEL_TAIL: begin
        if (empty) status = ple_pkg::ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx_x  = cnt_x - 1'b1;
        end
      end
      ple_pkg::ACT_INS_POS: begin
        if ((pos_x == '0) || (pos_x > cnt_x + 1'b1)) status = ple_pkg::ST_BADPOS;
        else if (full) status = ple_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          idx_x  = pos_x - 1'b1;
        end
      end
      ple_pkg::ACT_DEL_POS: begin
        if (empty) status = ple_pkg::ST_EMPTY;
        else if ((pos_x == '0) || (pos_x > cnt_x)) status = ple_pkg::ST_BADPOS;
        else begin
          do_del = 1'b1;
          idx_x  = pos_x - 1'b1;
        end
      end
      default: begin
        status = ple_pkg::ST_OK;
      end
    endcase
  end

  assign cmd = '{ins:   fire && do_ins,
                 del:   fire && do_del,
                 idx:   idx_x[ple_pkg::IDX_W-1:0],
                 value: value};

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins) cnt_nxt = cnt_r + 1'b1;
    else if (do_del) cnt_nxt = cnt_r - 1'b1;
  end

  assign cnt_nxt_x = ple_pkg::CMP_W'(cnt_nxt);
  assign occupancy = cnt_nxt_x[ple_pkg::OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/positional_list_engine_top.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_top
// bounded ordered list of signed 32-bit values kept in a row of shift cells
// ----------------------------------------------------------------------------
// usage
//   in_* carries one action per transfer (insert or delete at head, tail
//   or a 1-based position); out_* returns exactly one result per action:
//   status, removed value and occupancy after the action
//   the result of an action accepted at an edge is registered and shown on
//   out_* right after that edge
//   throughput is one action per cycle while the receiver takes each result;
//   every cell of the row shifts, loads or holds in the same cycle, decided
//   by a compare of its own index with the target index
//   a new action is accepted while the held result is taken in the same
//   cycle; when the receiver stalls, in_tready drops until out_* is taken
//   reset (rst_n low, synchronous) empties the list and drops out_tvalid;
//   the cell contents are not cleared and are never read before written
//   depth is ple_pkg::DEPTH entries
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // action[2:0], value[34:3], position[39:35]
  input  wire logic [ple_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // status[1:0], removed_value[33:2], occupancy[38:34], zero[39]
  output logic [ple_pkg::OUT_DATA_W-1:0]            out_tdata
);

  logic                               fire;
  logic [ple_pkg::ACT_W-1:0]          action;
  logic signed [ple_pkg::VAL_W-1:0]   value;
  logic [ple_pkg::POS_W-1:0]          position;
  ple_pkg::cell_cmd_t                 cmd;
  logic [ple_pkg::ST_W-1:0]           status;
  logic [ple_pkg::OCC_W-1:0]          occupancy;
  logic signed [ple_pkg::VAL_W-1:0]   cell_data [ple_pkg::DEPTH];
  logic signed [ple_pkg::VAL_W-1:0]   cell_rd   [ple_pkg::DEPTH];
  logic signed [ple_pkg::VAL_W-1:0]   removed;

  logic                               out_valid_r;
  logic [ple_pkg::ST_W-1:0]           status_r;
  logic signed [ple_pkg::VAL_W-1:0]   removed_r;
  logic [ple_pkg::OCC_W-1:0]          occ_r;

  assign action   = in_tdata[2:0];
  assign value    = in_tdata[34:3];
  assign position = in_tdata[39:35];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .action    (action),
    .value     (value),
    .position  (position),
    .cmd       (cmd),
    .status    (status),
    .occupancy (occupancy)
  );

  for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
    logic signed [ple_pkg::VAL_W-1:0] left_d;
    logic signed [ple_pkg::VAL_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == ple_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .my_idx     (ple_pkg::IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    removed = '0;
    for (int k = 0; k < ple_pkg::DEPTH; k++) begin
      removed = removed | cell_rd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status;
      removed_r <= removed;
      occ_r     <= occupancy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, occ_r, removed_r, status_r};

  // every accepted action yields a result on the next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("accepted action produced no result");

  // a rejected action removes nothing
  a_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status_r != ple_pkg::ST_OK)) |-> (removed_r == '0))
    else $error("removed value on a rejected action");

  // occupancy never exceeds the list depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ple_pkg::CMP_W'(occ_r) <= ple_pkg::CMP_W'(ple_pkg::DEPTH)))
    else $error("occupancy beyond depth");

  // full status only when the list already holds depth entries
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status_r == ple_pkg::ST_FULL))
      |-> (ple_pkg::CMP_W'(occ_r) == ple_pkg::CMP_W'(ple_pkg::DEPTH)))
    else $error("full status with room left");

  // empty status only when the list holds nothing
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status_r == ple_pkg::ST_EMPTY)) |-> (occ_r == '0))
    else $error("empty status with entries present");

endmodule

`default_nettype wire
